// ===== rtl/rsht_pkg.sv =====
package rsht_pkg;

    localparam int GEN_W = 16;
    localparam int TAG_W = 16;
    localparam int CTX_W = 32;
    localparam int SERIAL_W = 32;
    localparam int SLOT_NUM_W = 16;

    typedef enum logic [1:0] {
        KIND_ALLOC   = 2'd0,
        KIND_RELEASE = 2'd1,
        KIND_LOOKUP  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_BAD  = 2'd2,
        ST_FREE = 2'd3
    } status_t;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } fsm_t;

    typedef struct packed {
        logic [GEN_W-1:0] gen;
        logic [TAG_W-1:0] tag;
        logic [CTX_W-1:0] ctx;
    } slot_entry_t;

endpackage

// ===== rtl/reply_slot_handle_table_top.sv =====
// channel | ports                     | tdata (low bit up)                  | tuser
// in      | s_tvalid/s_tready/s_tdata | serial_in, handler_tag, ctx (80b)   | kind
// out     | m_tvalid/m_tready/m_tdata | serial_out, found_tag, ctx (80b)    | status, hit
//
// each request goes through accept plus slot memory read, then update and result.
// the registered read of the slot memory sets this split.
// reset brings every slot free with generation zero; no clearing pass is needed.
// a stalled result holds the block in its execute step until the output register frees.
module reply_slot_handle_table_top #(
    parameter int SLOTS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // serial_in[31:0], handler_tag[47:32], handler_context[79:48]
    input  logic [1:0]  s_tuser,   // kind[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // serial_out[31:0], found_tag[47:32], found_context[79:48]
    output logic [2:0]  m_tuser    // status[1:0], hit[2]
);
    import rsht_pkg::*;

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    fsm_t               state_reg, state_next;
    logic [SLOTS-1:0]   free_mask_reg, free_mask_next;

    logic [1:0]          kind_reg;
    logic [GEN_W-1:0]    gen_in_reg;
    logic [TAG_W-1:0]    tag_reg;
    logic [CTX_W-1:0]    ctx_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic                in_range_reg;
    logic                full_reg;

    logic                out_valid_reg, out_valid_next;
    logic [SERIAL_W-1:0] out_serial_reg, out_serial_next;
    status_t             out_status_reg, out_status_next;
    logic                out_hit_reg, out_hit_next;
    logic [TAG_W-1:0]    out_tag_reg, out_tag_next;
    logic [CTX_W-1:0]    out_ctx_reg, out_ctx_next;

    logic [SERIAL_W-1:0]   in_serial;
    logic [SLOT_NUM_W-1:0] in_num, in_num_m1;
    logic                  in_range;
    logic [IDX_W-1:0]      ffs_idx;
    logic [IDX_W-1:0]      rd_idx;
    logic                  accept;
    logic                  exec_go;

    slot_entry_t      rd_entry;
    slot_entry_t      wr_entry;
    logic             wr_en;
    logic [GEN_W-1:0] new_gen;

    assign in_serial = s_tdata[31:0];
    assign in_num    = in_serial[SLOT_NUM_W-1:0];
    assign in_num_m1 = in_num - SLOT_NUM_W'(1);
    assign in_range  = (in_num != '0) && (in_num <= SLOT_NUM_W'(SLOTS));

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign exec_go  = (state_reg == S_EXEC) && (!out_valid_reg || m_tready);

    // lowest free slot
    always_comb begin
        ffs_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (free_mask_reg[i]) begin
                ffs_idx = IDX_W'(i);
            end
        end
    end

    assign rd_idx = (s_tuser == KIND_ALLOC) ? ffs_idx : in_num_m1[IDX_W-1:0];

    rsht_slot_store #(
        .SLOTS(SLOTS)
    ) u_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (accept),
        .rd_idx   (rd_idx),
        .rd_entry (rd_entry),
        .wr_en    (wr_en),
        .wr_idx   (idx_reg),
        .wr_entry (wr_entry)
    );

    always_ff @(posedge aclk) begin
        if (accept) begin
            kind_reg     <= s_tuser;
            gen_in_reg   <= in_serial[SERIAL_W-1:SLOT_NUM_W];
            tag_reg      <= s_tdata[47:32];
            ctx_reg      <= s_tdata[79:48];
            idx_reg      <= rd_idx;
            in_range_reg <= in_range;
            full_reg     <= ~|free_mask_reg;
        end
    end

    assign new_gen      = rd_entry.gen + GEN_W'(1);
    assign wr_entry.gen = new_gen;
    assign wr_entry.tag = tag_reg;
    assign wr_entry.ctx = ctx_reg;

    always_comb begin
        state_next      = state_reg;
        free_mask_next  = free_mask_reg;
        wr_en           = 1'b0;
        out_valid_next  = out_valid_reg && !m_tready;
        out_serial_next = out_serial_reg;
        out_status_next = out_status_reg;
        out_hit_next    = out_hit_reg;
        out_tag_next    = out_tag_reg;
        out_ctx_next    = out_ctx_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (exec_go) begin
                    state_next      = S_IDLE;
                    out_valid_next  = 1'b1;
                    out_serial_next = '0;
                    out_status_next = ST_OK;
                    out_hit_next    = 1'b0;
                    out_tag_next    = '0;
                    out_ctx_next    = '0;
                    case (kind_reg) inside
                        KIND_ALLOC: begin
                            if (full_reg) begin
                                out_status_next = ST_FULL;
                            end else begin
                                wr_en                   = 1'b1;
                                free_mask_next[idx_reg] = 1'b0;
                                out_serial_next = {new_gen,
                                                   SLOT_NUM_W'(idx_reg) + SLOT_NUM_W'(1)};
                            end
                        end
                        KIND_RELEASE, KIND_LOOKUP: begin
                            // generation is checked before the busy flag
                            if (!in_range_reg || rd_entry.gen != gen_in_reg) begin
                                out_status_next = ST_BAD;
                            end else if (free_mask_reg[idx_reg]) begin
                                out_status_next = ST_FREE;
                            end else if (kind_reg == KIND_RELEASE) begin
                                free_mask_next[idx_reg] = 1'b1;
                            end else begin
                                out_hit_next = 1'b1;
                                out_tag_next = rd_entry.tag;
                                out_ctx_next = rd_entry.ctx;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            free_mask_reg <= '1;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            free_mask_reg <= free_mask_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_serial_reg <= out_serial_next;
        out_status_reg <= out_status_next;
        out_hit_reg    <= out_hit_next;
        out_tag_reg    <= out_tag_next;
        out_ctx_reg    <= out_ctx_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_ctx_reg, out_tag_reg, out_serial_reg};
    assign m_tuser  = {out_hit_reg, out_status_reg};

endmodule

// ===== rtl/rsht_slot_store.sv =====
module rsht_slot_store #(
    parameter int SLOTS = 16,
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 rd_en,
    input  logic [IDX_W-1:0]     rd_idx,
    output rsht_pkg::slot_entry_t rd_entry,
    input  logic                 wr_en,
    input  logic [IDX_W-1:0]     wr_idx,
    input  rsht_pkg::slot_entry_t wr_entry
);
    import rsht_pkg::*;

    slot_entry_t       mem [SLOTS];
    logic [SLOTS-1:0]  gen_valid_reg;
    slot_entry_t       rd_data_reg;
    logic              rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_idx] <= wr_entry;
        end
        if (rd_en) begin
            rd_data_reg  <= mem[rd_idx];
            rd_valid_reg <= gen_valid_reg[rd_idx];
        end
    end

    // generation reads as zero until the slot has been allocated once
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gen_valid_reg <= '0;
        end else if (wr_en) begin
            gen_valid_reg[wr_idx] <= 1'b1;
        end
    end

    always_comb begin
        rd_entry     = rd_data_reg;
        rd_entry.gen = rd_valid_reg ? rd_data_reg.gen : '0;
    end

endmodule
